// ----- src/circular_deque_top_assert.svh -----
// Assertion macros for the circular deque block.
// Included by circular_deque_top.sv; relies on nothing else.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cdq_pkg.sv -----
// Shared types, constants and ring index helpers for the circular deque.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CAP_W     = 5;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam cap_t CAP_RESET = cap_t'(16);
  localparam cap_t CAP_MAX   = cap_t'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  // Classified item handed from the front end to the execution side.
  typedef struct packed {
    logic  is_push;
    logic  at_front;
    data_t value;
  } cmd_t;

  typedef struct packed {
    logic  done_res;
    data_t popped_value;
    logic  is_empty;
    logic  is_full;
    data_t front_value;
    data_t rear_value;
  } result_t;

  // Zero acts as one slot, anything above the built depth saturates.
  function automatic cap_t cap_eff(input cap_t c);
    cap_t r;
    if (c == '0) begin
      r = cap_t'(1);
    end else if (c > CAP_MAX) begin
      r = CAP_MAX;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic idx_t ring_next(input idx_t i, input cap_t cap);
    cap_t nxt;
    nxt = cap_t'(i) + cap_t'(1);
    return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic idx_t ring_prev(input idx_t i, input cap_t cap);
    cap_t last;
    last = cap - cap_t'(1);
    return (i == '0) ? last[IDX_W-1:0] : i - idx_t'(1);
  endfunction

endpackage

`default_nettype wire

// ----- src/cdq_ifs.sv -----
// Channel interfaces of the circular deque: request, result and capacity write.
// Depends on cdq_pkg for field types.
`default_nettype none

interface cdq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  cdq_pkg::data_t     push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic               valid;
  logic               ready;
  logic               done_res;
  cdq_pkg::data_t     popped_value;
  logic               is_empty;
  logic               is_full;
  cdq_pkg::data_t     front_value;
  cdq_pkg::data_t     rear_value;

  modport source (output valid, output done_res, output popped_value, output is_empty,
                  output is_full, output front_value, output rear_value, input ready);
  modport sink   (input valid, input done_res, input popped_value, input is_empty,
                  input is_full, input front_value, input rear_value, output ready);
endinterface

interface cdq_cfg_if;
  logic               valid;
  logic               ready;
  cdq_pkg::cap_t      capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ----- src/cdq_front.sv -----
// Front end: accepts request items, classifies the op and buffers them in a
// two-entry queue toward the execution side. Depends on cdq_pkg, cdq_ifs.
`default_nettype none

module cdq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  cdq_req_if.sink            req,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output cdq_pkg::cmd_t      cmd
);

  cdq_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  cdq_pkg::cmd_t in_cmd;
  cdq_pkg::op_t  op;
  logic          push;
  logic          pop;

  assign op = cdq_pkg::op_t'(req.op);

  always_comb begin
    in_cmd.is_push  = (op == cdq_pkg::OP_PUSH_FRONT) || (op == cdq_pkg::OP_PUSH_REAR);
    in_cmd.at_front = (op == cdq_pkg::OP_PUSH_FRONT) || (op == cdq_pkg::OP_POP_FRONT);
    in_cmd.value    = req.push_value;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- src/cdq_back.sv -----
// Execution side: ring pointers, slot memory, cached front/rear entries and
// the result register. Depends on cdq_pkg and cdq_ifs.
`default_nettype none

module cdq_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  cdq_pkg::cmd_t      cmd,
  cdq_cfg_if.sink            cfg,
  cdq_rsp_if.source          rsp
);

  typedef enum logic [1:0] {
    ST_EXEC  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t            state;
  cdq_pkg::cap_t     capacity;
  cdq_pkg::idx_t     head;
  cdq_pkg::idx_t     tail;
  logic              empty_flag;
  cdq_pkg::data_t    front_reg;
  cdq_pkg::data_t    rear_reg;
  logic              out_valid;
  logic              fetch_front;
  cdq_pkg::result_t  res;

  cdq_pkg::idx_t     head_next;
  cdq_pkg::idx_t     tail_next;
  logic              empty_next;
  cdq_pkg::data_t    front_next;
  cdq_pkg::data_t    rear_next;
  cdq_pkg::result_t  res_next;
  cdq_pkg::cap_t     cap;
  logic              full_now;
  logic              need_fetch;
  logic              take;
  logic              cfg_wr;

  cdq_pkg::data_t    ring [cdq_pkg::DEPTH];
  logic              mem_we;
  cdq_pkg::idx_t     mem_waddr;
  cdq_pkg::idx_t     mem_raddr;
  cdq_pkg::data_t    mem_rdata;

  assign cap       = cdq_pkg::cap_eff(capacity);
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cmd_ready = (state == ST_EXEC) && (!out_valid || rsp.ready);
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty_flag;
    front_next = front_reg;
    rear_next  = rear_reg;
    mem_we     = 1'b0;
    mem_waddr  = head;
    mem_raddr  = head;
    need_fetch = 1'b0;
    res_next   = '0;
    full_now   = !empty_flag && (cdq_pkg::ring_next(tail, cap) == head);

    if (cmd.is_push) begin
      if (!full_now) begin
        res_next.done_res = 1'b1;
        mem_we            = take;
        if (empty_flag) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          mem_waddr  = '0;
          front_next = cmd.value;
          rear_next  = cmd.value;
        end else if (cmd.at_front) begin
          head_next  = cdq_pkg::ring_prev(head, cap);
          mem_waddr  = head_next;
          front_next = cmd.value;
        end else begin
          tail_next  = cdq_pkg::ring_next(tail, cap);
          mem_waddr  = tail_next;
          rear_next  = cmd.value;
        end
      end
    end else if (!empty_flag) begin
      res_next.done_res     = 1'b1;
      res_next.popped_value = cmd.at_front ? front_reg : rear_reg;
      if (head == tail) begin
        empty_next = 1'b1;
      end else if (cmd.at_front) begin
        // new front entry comes back from the slot memory next cycle
        head_next  = cdq_pkg::ring_next(head, cap);
        mem_raddr  = head_next;
        need_fetch = 1'b1;
      end else begin
        tail_next  = cdq_pkg::ring_prev(tail, cap);
        mem_raddr  = tail_next;
        need_fetch = 1'b1;
      end
    end

    res_next.is_empty    = empty_next;
    res_next.is_full     = !empty_next && (cdq_pkg::ring_next(tail_next, cap) == head_next);
    res_next.front_value = empty_next ? '0 : front_next;
    res_next.rear_value  = empty_next ? '0 : rear_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_EXEC;
      capacity   <= cdq_pkg::CAP_RESET;
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
      out_valid  <= 1'b0;
    end else if (cfg_wr) begin
      capacity   <= cfg.capacity;
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
    end else if (take) begin
      head       <= head_next;
      tail       <= tail_next;
      empty_flag <= empty_next;
      out_valid  <= !need_fetch;
      state      <= need_fetch ? ST_FETCH : ST_EXEC;
    end else if (state == ST_FETCH) begin
      out_valid  <= 1'b1;
      state      <= ST_EXEC;
    end else if (rsp.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res         <= res_next;
      front_reg   <= front_next;
      rear_reg    <= rear_next;
      fetch_front <= cmd.at_front;
    end else if (state == ST_FETCH) begin
      if (fetch_front) begin
        front_reg       <= mem_rdata;
        res.front_value <= mem_rdata;
      end else begin
        rear_reg        <= mem_rdata;
        res.rear_value  <= mem_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= cmd.value;
    end
    mem_rdata <= ring[mem_raddr];
  end

  assign rsp.valid        = out_valid;
  assign rsp.done_res     = res.done_res;
  assign rsp.popped_value = res.popped_value;
  assign rsp.is_empty     = res.is_empty;
  assign rsp.is_full      = res.is_full;
  assign rsp.front_value  = res.front_value;
  assign rsp.rear_value   = res.rear_value;

endmodule

`default_nettype wire

// ----- src/circular_deque_top.sv -----
// Circular deque: a double-ended queue of signed 32-bit entries in a ring of
// up to 16 slots.
// Channels: req carries op and push_value, rsp returns one result item per
// request (done flag, popped entry, empty/full flags, front and rear
// entries), cfg writes the ring capacity. All use valid/ready; a transfer
// happens on a rising edge with both high.
// A request item passes through the front-end queue and the result register
// before its result item is valid on rsp. A pop that leaves entries behind
// also reads the new front or rear entry from the single read port of the
// slot memory in a fetch state before its result item is valid.
// Throughput: one item per cycle while rsp is ready, for pushes, refused ops
// and pops that empty the deque; other pops block the next item while fetching.
// A two-entry queue sits between request intake and execution, and the
// result register accepts the next item in the cycle it is drained, so a
// stalled rsp backs up into that queue and then deasserts req.ready.
// Reset (rst, synchronous): deque empty, capacity 16. A capacity write also
// empties the deque; write it only while no request is in flight.
// Depends on cdq_pkg, cdq_ifs, cdq_front, cdq_back.
`default_nettype none

`include "circular_deque_top_assert.svh"

module circular_deque_top (
  input  wire logic   clk,
  input  wire logic   rst,
  cdq_req_if.sink     req,
  cdq_rsp_if.source   rsp,
  cdq_cfg_if.sink     cfg
);

  logic          cmd_valid;
  logic          cmd_ready;
  cdq_pkg::cmd_t cmd;

  cdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  cdq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg),
    .rsp       (rsp)
  );

  `CDQ_ASSERT_NOW(a_empty_full_excl, clk, rst, rsp.valid,
                  !(rsp.is_empty && rsp.is_full), "deque reported both empty and full")
  `CDQ_ASSERT_NOW(a_empty_zero, clk, rst, rsp.valid && rsp.is_empty,
                  (rsp.front_value == '0) && (rsp.rear_value == '0),
                  "empty deque shows nonzero front or rear")
  `CDQ_ASSERT_NOW(a_refused_zero, clk, rst, rsp.valid && !rsp.done_res,
                  rsp.popped_value == '0, "refused op carries a popped entry")
  `CDQ_ASSERT_NEXT(a_req_queued, clk, rst, req.valid && req.ready, cmd_valid,
                   "accepted item missing from the command queue")

endmodule

`default_nettype wire

// ----- sim/circular_deque_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for circular_deque_top: directed and random deque operations over several
// capacities, each result checked field by field against an in-bench deque predictor.
// Depends on cdq_pkg, the cdq_ifs channel interfaces and the circular_deque_top RTL.

module circular_deque_top_test;
  import cdq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 130;
  localparam int NUM_PHASES     = 10;

  typedef struct {
    op_t   op;
    data_t value;
  } deque_cmd_t;

  logic clk;
  logic rst;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();
  cdq_cfg_if cfg_ch ();

  circular_deque_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  deque_cmd_t cmd_backlog [$];
  result_t    status_due [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatches   = 0;
  int ops_checked  = 0;
  int full_seen    = 0;
  int refused_seen = 0;
  int cap_writes   = 0;
  int stall_cycles = 0;

  // Predicted deque contents and pointers
  data_t ring_mem [DEPTH];
  int    front_idx;
  int    rear_idx;
  bit    ring_empty;
  cap_t  cap_setting;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int slots_in_use();
    if (cap_setting == '0) return 1;
    if (cap_setting > CAP_MAX) return DEPTH;
    return int'(cap_setting);
  endfunction

  function automatic int wrap_up(int i, int n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic int wrap_down(int i, int n);
    return (i == 0) ? n - 1 : i - 1;
  endfunction

  function automatic bit ring_full(int n);
    return !ring_empty && wrap_up(rear_idx, n) == front_idx;
  endfunction

  function automatic result_t deque_apply(op_t op, data_t value);
    int      n;
    result_t r;
    n = slots_in_use();
    r = '0;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (!ring_full(n)) begin
        // first entry always lands in slot 0
        if (ring_empty) begin
          front_idx   = 0;
          rear_idx    = 0;
          ring_empty  = 1'b0;
          ring_mem[0] = value;
        end else if (op == OP_PUSH_FRONT) begin
          front_idx           = wrap_down(front_idx, n);
          ring_mem[front_idx] = value;
        end else begin
          rear_idx           = wrap_up(rear_idx, n);
          ring_mem[rear_idx] = value;
        end
        r.done_res = 1'b1;
      end
    end else if (!ring_empty) begin
      if (op == OP_POP_FRONT) begin
        r.popped_value = ring_mem[front_idx];
        if (front_idx == rear_idx) ring_empty = 1'b1;
        else front_idx = wrap_up(front_idx, n);
      end else begin
        r.popped_value = ring_mem[rear_idx];
        if (front_idx == rear_idx) ring_empty = 1'b1;
        else rear_idx = wrap_down(rear_idx, n);
      end
      r.done_res = 1'b1;
    end
    r.is_empty    = ring_empty;
    r.is_full     = ring_full(n);
    r.front_value = ring_empty ? data_t'(0) : ring_mem[front_idx];
    r.rear_value  = ring_empty ? data_t'(0) : ring_mem[rear_idx];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    deque_cmd_t next_cmd;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        next_cmd = cmd_backlog.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.op         <= next_cmd.op;
        req_ch.push_value <= next_cmd.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Monitor: predicts on request items, checks result items
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      front_idx   = 0;
      rear_idx    = 0;
      ring_empty  = 1'b1;
      cap_setting = CAP_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_setting = cfg_ch.capacity;
        front_idx   = 0;
        rear_idx    = 0;
        ring_empty  = 1'b1;
        cap_writes++;
      end
      if (req_ch.valid && req_ch.ready)
        status_due.push_back(deque_apply(op_t'(req_ch.op), req_ch.push_value));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: result item with nothing expected, expected none, actual done %b popped %h",
                   $time, rsp_ch.done_res, rsp_ch.popped_value);
        end else begin
          want = status_due.pop_front();
          check_field("done_res", 32'(want.done_res), 32'(rsp_ch.done_res));
          check_field("popped_value", want.popped_value, rsp_ch.popped_value);
          check_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(rsp_ch.is_full));
          check_field("front_value", want.front_value, rsp_ch.front_value);
          check_field("rear_value", want.rear_value, rsp_ch.rear_value);
          ops_checked++;
          if (rsp_ch.is_full) full_seen++;
          if (!rsp_ch.done_res) refused_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_cmd(op_t op, data_t value);
    deque_cmd_t c;
    c.op    = op;
    c.value = value;
    cmd_backlog.push_back(c);
  endtask

  // Returns once nothing is queued, in flight or awaiting a result; sampled on the
  // falling edge so the driver's and monitor's updates of the rising edge have settled
  task automatic wait_quiet();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || req_ch.valid || status_due.size() != 0);
  endtask

  task automatic write_capacity(cap_t value);
    wait_quiet();
    @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(9, 0))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return data_t'($urandom());
    endcase
  endfunction

  // Alternating fill and drain runs so the ring hits full, empty and wraps often
  task automatic random_phase(cap_t cap, int count);
    int  n;
    int  run_left;
    int  push_pct;
    op_t op;
    write_capacity(cap);
    push_pct = 15;
    run_left = 0;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) wait_quiet();
      if (run_left == 0) begin
        run_left = $urandom_range(40, 2);
        push_pct = 100 - push_pct;
      end
      run_left--;
      if ($urandom_range(99, 0) < push_pct)
        op = $urandom_range(1, 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      else
        op = $urandom_range(1, 0) ? OP_POP_REAR : OP_POP_FRONT;
      queue_cmd(op, pick_value());
    end
  endtask

  initial begin
    cap_t phase_caps [NUM_PHASES];
    int   p;
    phase_caps = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd0, 5'd3, 5'd17, 5'd8, 5'd2, 5'd16};

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_PUSH_FRONT;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.capacity   = CAP_RESET;
    tx_idle_pct       = 10;
    rx_idle_pct       = 56;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: pops on empty, extremes, last-entry pop, push into empty
    queue_cmd(OP_POP_FRONT, 32'sd7);
    queue_cmd(OP_POP_REAR, 32'sd7);
    queue_cmd(OP_PUSH_REAR, 32'sh7fff_ffff);
    queue_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
    queue_cmd(OP_POP_REAR, '0);
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_PUSH_FRONT, '0);
    queue_cmd(OP_PUSH_REAR, -1);
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_POP_REAR, '0);

    // Two slots: fill, refused pushes when full, drain, refused pop
    write_capacity(5'd2);
    queue_cmd(OP_PUSH_FRONT, 32'sd1);
    queue_cmd(OP_PUSH_REAR, 32'sd2);
    queue_cmd(OP_PUSH_REAR, 32'sd3);
    queue_cmd(OP_PUSH_FRONT, 32'sd4);
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_POP_REAR, '0);
    queue_cmd(OP_POP_REAR, '0);

    // Zero capacity acts as a single slot
    write_capacity(5'd0);
    queue_cmd(OP_PUSH_REAR, 32'sh5a5a_a5a5);
    queue_cmd(OP_PUSH_FRONT, 32'sh1234_5678);
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_POP_FRONT, '0);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      if (p < 4) begin
        tx_idle_pct = 10;
        rx_idle_pct = 56;
      end else if (p < 7) begin
        tx_idle_pct = 56;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_phase(phase_caps[p], PHASE_ITEMS);
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d deque operations over %0d capacity writes", ops_checked, cap_writes);
    $display("  %0d refused, %0d left the deque full", refused_seen, full_seen);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/cdq_pkg.sv
src/cdq_ifs.sv
src/cdq_front.sv
src/cdq_back.sv
src/circular_deque_top.sv
sim/circular_deque_top_test.sv
